// File: sv/tto_pkg.sv
// ----------------------------------------------------------------------------
// tto_pkg: shared constants, types and font for the timestamp text overlay
// Holds the text geometry, the paint colors, the glyph font and the
// character-to-glyph mapping used by the overlay logic.
// ----------------------------------------------------------------------------
`default_nettype none

package tto_pkg;

  localparam int NUM_CHARS  = 17;
  localparam int COORD_BITS = 12;
  localparam int BLOCK_BITS = COORD_BITS - 4;
  localparam int MAX_CHARS  = 17;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 64;

  localparam logic [15:0] WHITE_WORD = 16'heb80;
  localparam logic [15:0] BLACK_WORD = 16'h1080;

  localparam logic [3:0] GLYPH_SLASH = 4'd10;
  localparam logic [3:0] GLYPH_COLON = 4'd11;
  localparam logic [3:0] GLYPH_BLANK = 4'd12;

  localparam logic [7:0] CODE_ZERO  = 8'd48;
  localparam logic [7:0] CODE_NINE  = 8'd57;
  localparam logic [7:0] CODE_SLASH = 8'd47;
  localparam logic [7:0] CODE_COLON = 8'd58;

  typedef enum logic [1:0] {
    REG_CHARS_LOW = 2'd0,
    REG_CHARS_MID = 2'd1,
    REG_CHAR_LAST = 2'd2
  } reg_idx_e;

  typedef logic [NUM_CHARS-1:0][7:0] text_t;
  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic paint;
    logic black;
  } mark_t;

  localparam logic [7:0] GLYPH_ROWS [13][16] = '{
    '{8'h00,8'h00,8'h3c,8'h3c,8'h66,8'h66,8'h6e,8'h6e,
      8'h76,8'h76,8'h66,8'h66,8'h3c,8'h3c,8'h00,8'h00},
    '{8'h00,8'h00,8'h18,8'h18,8'h38,8'h38,8'h18,8'h18,
      8'h18,8'h18,8'h18,8'h18,8'h7e,8'h7e,8'h00,8'h00},
    '{8'h00,8'h00,8'h3c,8'h3c,8'h66,8'h66,8'h0c,8'h0c,
      8'h18,8'h18,8'h30,8'h30,8'h7e,8'h7e,8'h00,8'h00},
    '{8'h00,8'h00,8'h7e,8'h7e,8'h0c,8'h0c,8'h18,8'h18,
      8'h0c,8'h0c,8'h66,8'h66,8'h3c,8'h3c,8'h00,8'h00},
    '{8'h00,8'h00,8'h0c,8'h0c,8'h1c,8'h1c,8'h3c,8'h3c,
      8'h6c,8'h6c,8'h7e,8'h7e,8'h0c,8'h0c,8'h00,8'h00},
    '{8'h00,8'h00,8'h7e,8'h7e,8'h60,8'h60,8'h7c,8'h7c,
      8'h06,8'h06,8'h66,8'h66,8'h3c,8'h3c,8'h00,8'h00},
    '{8'h00,8'h00,8'h3c,8'h3c,8'h60,8'h60,8'h7c,8'h7c,
      8'h66,8'h66,8'h66,8'h66,8'h3c,8'h3c,8'h00,8'h00},
    '{8'h00,8'h00,8'h7e,8'h7e,8'h06,8'h06,8'h0c,8'h0c,
      8'h18,8'h18,8'h30,8'h30,8'h30,8'h30,8'h00,8'h00},
    '{8'h00,8'h00,8'h3c,8'h3c,8'h66,8'h66,8'h3c,8'h3c,
      8'h66,8'h66,8'h66,8'h66,8'h3c,8'h3c,8'h00,8'h00},
    '{8'h00,8'h00,8'h3c,8'h3c,8'h66,8'h66,8'h3e,8'h3e,
      8'h06,8'h06,8'h0c,8'h0c,8'h38,8'h38,8'h00,8'h00},
    '{8'h00,8'h00,8'h06,8'h06,8'h0c,8'h0c,8'h18,8'h18,
      8'h30,8'h30,8'h60,8'h60,8'h40,8'h40,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'h00,8'h18,8'h18,8'h18,8'h18,
      8'h00,8'h00,8'h18,8'h18,8'h18,8'h18,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}
  };

  function automatic logic [3:0] glyph_of(input logic [7:0] code);
    logic [3:0] g;
    if (code >= CODE_ZERO && code <= CODE_NINE) begin
      g = 4'(code - CODE_ZERO);
    end else if (code == CODE_SLASH) begin
      g = GLYPH_SLASH;
    end else if (code == CODE_COLON) begin
      g = GLYPH_COLON;
    end else begin
      g = GLYPH_BLANK;
    end
    return g;
  endfunction

  function automatic logic [7:0] glyph_row(input logic [3:0] g, input logic [3:0] r);
    logic [7:0] bits;
    if (g > GLYPH_BLANK) begin
      bits = 8'h00;
    end else begin
      bits = GLYPH_ROWS[g][r];
    end
    return bits;
  endfunction

endpackage

`default_nettype wire

// File: sv/timestamp_text_overlay_unit.sv
// ----------------------------------------------------------------------------
// timestamp_text_overlay_unit: bitmap font text overlay on a pixel stream
// Paints a 17-character text with a drop shadow onto packed pixel words.
//
// The input channel takes one pixel word per item with its column and line;
// an item is accepted when in_valid_i is high and in_stall_o is low. Each
// item gives exactly one result item on the output channel, taken when
// out_valid_o is high and out_stall_i is low. An item passes through an
// input register and a result register, and its result is shown once it
// has moved on into the result register. With no stall one item is taken
// every cycle; the glyph lookup between the two registers is combinational.
// When the receiver stalls, the result register holds its item and the
// input register fills, after which in_stall_o rises; no item is lost.
// The user is to write the text over the APB-style port only while no
// item is in flight; the block itself does not enforce this.
// Reset empties both registers and clears the text to all zero codes,
// which draw nothing, so words pass through unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_text_overlay_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tto_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [tto_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [tto_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [15:0]                     pixel_in_i,
  input  wire tto_pkg::coord_t                 word_column_i,
  input  wire tto_pkg::coord_t                 line_number_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [15:0]                     pixel_out_o
);
  import tto_pkg::*;

  text_t       text;
  mark_t       mark;
  logic        s1_valid_q;
  logic [15:0] s1_pixel_q;
  coord_t      s1_col_q;
  coord_t      s1_line_q;
  logic        out_valid_q;
  logic [15:0] pixel_out_q;
  logic [15:0] pixel_out_d;
  logic        out_en;
  logic        s1_en;

  tto_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .text_o  (text)
  );

  tto_mark_logic u_mark_logic (
    .col_i  (s1_col_q),
    .line_i (s1_line_q),
    .text_i (text),
    .mark_o (mark)
  );

  assign out_en     = !out_valid_q || !out_stall_i;
  assign s1_en      = !s1_valid_q || out_en;
  assign in_stall_o = !s1_en;

  always_comb begin
    pixel_out_d = s1_pixel_q;
    if (mark.paint) begin
      pixel_out_d = mark.black ? BLACK_WORD : WHITE_WORD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_en) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_pixel_q <= pixel_in_i;
      s1_col_q   <= word_column_i;
      s1_line_q  <= line_number_i;
    end
    if (out_en && s1_valid_q) begin
      pixel_out_q <= pixel_out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_out_q;

endmodule

`default_nettype wire

// File: sv/tto_cfg_regs.sv
// ----------------------------------------------------------------------------
// tto_cfg_regs: configuration registers of the timestamp text overlay
// APB-style register port holding the ASCII text, 64-bit data, one
// register every eight bytes, with zero wait states.
// ----------------------------------------------------------------------------
`default_nettype none

module tto_cfg_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [tto_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [tto_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [tto_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  output tto_pkg::text_t                         text_o
);
  import tto_pkg::*;

  logic [63:0] chars_low_q;
  logic [63:0] chars_mid_q;
  logic [7:0]  char_last_q;
  logic        wr_en;
  logic [1:0]  reg_idx;
  logic [MAX_CHARS-1:0][7:0] all_chars;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_low_q <= '0;
      chars_mid_q <= '0;
      char_last_q <= '0;
    end else if (wr_en && paddr[2:0] == 3'd0) begin
      unique case (reg_idx)
        REG_CHARS_LOW: chars_low_q <= pwdata;
        REG_CHARS_MID: chars_mid_q <= pwdata;
        REG_CHAR_LAST: char_last_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'd0) begin
      unique case (reg_idx)
        REG_CHARS_LOW: prdata = chars_low_q;
        REG_CHARS_MID: prdata = chars_mid_q;
        REG_CHAR_LAST: prdata = {56'd0, char_last_q};
        default:       prdata = '0;
      endcase
    end
  end

  assign all_chars = {char_last_q, chars_mid_q, chars_low_q};
  assign text_o    = all_chars[NUM_CHARS-1:0];

endmodule

`default_nettype wire

// File: sv/tto_mark_logic.sv
// ----------------------------------------------------------------------------
// tto_mark_logic: glyph hit test for one pixel word
// Finds the character under the word and its left neighbor, and decides
// whether the word is painted white, painted with shadow, or left alone.
// ----------------------------------------------------------------------------
`default_nettype none

module tto_mark_logic (
  input  wire tto_pkg::coord_t col_i,
  input  wire tto_pkg::coord_t line_i,
  input  wire tto_pkg::text_t  text_i,
  output tto_pkg::mark_t       mark_o
);
  import tto_pkg::*;

  logic [BLOCK_BITS-1:0] block;
  logic [3:0]            sub;
  logic [7:0]            cur_code;
  logic [7:0]            prev_code;
  logic [7:0]            cur_row_w;
  logic [7:0]            cur_row_b;
  logic [7:0]            prev_row_b;
  coord_t                line_w;
  coord_t                line_b;
  logic                  row_w_ok;
  logic                  row_b_ok;
  logic [3:0]            dx_b;
  logic                  hit_cur_w;
  logic                  hit_cur_b;
  logic                  hit_prev_b;

  assign block = col_i[COORD_BITS-1:4];
  assign sub   = col_i[3:0];

  always_comb begin
    cur_code  = 8'd0;
    prev_code = 8'd0;
    for (int i = 0; i < NUM_CHARS; i++) begin
      if (block == BLOCK_BITS'(i + 1)) begin
        cur_code = text_i[i];
      end
      if (block == BLOCK_BITS'(i + 2)) begin
        prev_code = text_i[i];
      end
    end
  end

  assign line_w   = line_i - COORD_BITS'(16);
  assign line_b   = line_i - COORD_BITS'(17);
  assign row_w_ok = (line_i >= COORD_BITS'(16)) && (line_w[COORD_BITS-1:4] == '0);
  assign row_b_ok = (line_i >= COORD_BITS'(17)) && (line_b[COORD_BITS-1:4] == '0);

  assign cur_row_w  = glyph_row(glyph_of(cur_code), line_w[3:0]);
  assign cur_row_b  = glyph_row(glyph_of(cur_code), line_b[3:0]);
  assign prev_row_b = glyph_row(glyph_of(prev_code), line_b[3:0]);

  assign dx_b = sub - 4'd2;

  assign hit_cur_w  = row_w_ok && cur_row_w[~sub[3:1]];
  assign hit_cur_b  = row_b_ok && (sub >= 4'd2) && cur_row_b[~dx_b[3:1]];
  assign hit_prev_b = row_b_ok && (sub < 4'd2) && prev_row_b[0];

  always_comb begin
    mark_o.paint = hit_cur_w || hit_cur_b || hit_prev_b;
    mark_o.black = hit_cur_b || (!hit_cur_w && hit_prev_b);
  end

endmodule

`default_nettype wire
